// ===== src/tdcwd_pkg.sv =====
// Shared types, constants and word classification for the TDC word decoder.
// No dependencies; the RTL refers to it by scoped names, the bench imports it.
package tdcwd_pkg;

  // sizing of the hit store
  localparam int CHANNELS  = 128;
  localparam int MAX_HITS  = 128;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W     = $clog2(MAX_HITS + 1);
  localparam int TADDR_W   = (CHANNELS * MAX_HITS > 1) ? $clog2(CHANNELS * MAX_HITS) : 1;

  // field widths
  localparam int OP_W      = 2;
  localparam int WORD_W    = 32;
  localparam int CHAN_W    = 7;
  localparam int HIDX_W    = 7;
  localparam int KIND_W    = 3;
  localparam int EVENT_W   = 22;
  localparam int SLOT_W    = 5;
  localparam int TIME_W    = 19;
  localparam int WCNT_W    = 16;
  localparam int ECHIP_W   = 2;
  localparam int EFLAG_W   = 15;
  localparam int RCNT_W    = 8;

  // stream widths
  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = OP_W;
  localparam int M_TDATA_W = 120;
  localparam int M_TUSER_W = KIND_W;

  // operations
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // word kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_FILLER = 3'd0,
    KIND_GHDR   = 3'd1,
    KIND_CHDR   = 3'd2,
    KIND_MEAS   = 3'd3,
    KIND_CTRL   = 3'd4,
    KIND_GTRL   = 3'd5,
    KIND_ERROR  = 3'd6,
    KIND_UNKNOWN = 3'd7
  } kind_e;

  // type tags in bits 31..27 of a readout word
  localparam logic [4:0] TAG_FILLER = 5'b11000;
  localparam logic [4:0] TAG_GHDR   = 5'b01000;
  localparam logic [4:0] TAG_CHDR   = 5'b00001;
  localparam logic [4:0] TAG_MEAS   = 5'b00000;
  localparam logic [4:0] TAG_CTRL   = 5'b00011;
  localparam logic [4:0] TAG_GTRL   = 5'b10000;
  localparam logic [4:0] TAG_ERROR  = 5'b00100;

  function automatic kind_e classify(input logic [WORD_W-1:0] w);
    kind_e k;
    case (w[31:27])
      TAG_FILLER: k = KIND_FILLER;
      TAG_GHDR:   k = KIND_GHDR;
      TAG_CHDR:   k = KIND_CHDR;
      TAG_MEAS:   k = KIND_MEAS;
      TAG_CTRL:   k = KIND_CTRL;
      TAG_GTRL:   k = KIND_GTRL;
      TAG_ERROR:  k = KIND_ERROR;
      default:    k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // controller to datapath
  typedef struct packed {
    logic load;  // capture request, start memory reads
    logic exec;  // update state, load result register
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [KIND_W-1:0]  word_kind;
    logic [EVENT_W-1:0] event_number;
    logic [SLOT_W-1:0]  slot_number;
    logic [CHAN_W-1:0]  hit_channel;
    logic [TIME_W-1:0]  hit_time;
    logic               hit_stored;
    logic               event_done;
    logic [WCNT_W-1:0]  words_seen;
    logic [ECHIP_W-1:0] error_chip;
    logic [EFLAG_W-1:0] error_flags;
    logic [TIME_W-1:0]  read_value;
    logic [RCNT_W-1:0]  read_count;
  } res_t;

endpackage

// ===== src/tdcwd_ctrl.sv =====
// Controller for the TDC word decoder: request handshake, execute step and
// result-valid flag. Depends on tdcwd_pkg.
module tdcwd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output tdcwd_pkg::cmd_t    cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  // take a request only when the result register is free by the exec cycle
  assign s_ready_o = (state_q == ST_IDLE) && (!out_valid_q || m_ready_i);
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_EXEC) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o  = out_valid_q;
  assign cmd_o.load = accept;
  assign cmd_o.exec = (state_q == ST_EXEC);

endmodule

// ===== src/tdcwd_datapath.sv =====
// Datapath for the TDC word decoder: event latches, word counter, per-channel
// hit counts and the hit time store. Depends on tdcwd_pkg.
module tdcwd_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tdcwd_pkg::cmd_t                   cmd_i,
  input  logic [tdcwd_pkg::OP_W-1:0]        opcode_i,
  input  logic [tdcwd_pkg::WORD_W-1:0]      data_word_i,
  input  logic [tdcwd_pkg::CHAN_W-1:0]      read_channel_i,
  input  logic [tdcwd_pkg::HIDX_W-1:0]      read_hit_i,
  output tdcwd_pkg::res_t                   res_o
);

  // captured request
  logic [tdcwd_pkg::OP_W-1:0]   op_q;
  logic [tdcwd_pkg::WORD_W-1:0] word_q;
  logic [tdcwd_pkg::HIDX_W-1:0] rhit_q;
  logic                         ch_ok_q;
  logic                         hit_ok_q;

  // architectural state
  logic [tdcwd_pkg::EVENT_W-1:0] event_q, event_d;
  logic [tdcwd_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic                          trailer_q, trailer_d;
  logic [tdcwd_pkg::WCNT_W-1:0]  wcnt_q, wcnt_d;
  logic [tdcwd_pkg::CHANNELS-1:0] cnt_vld_q, cnt_vld_d;

  // memories
  logic [tdcwd_pkg::CNT_W-1:0]  cnt_mem [tdcwd_pkg::CHANNELS];
  logic [tdcwd_pkg::TIME_W-1:0] time_mem [tdcwd_pkg::CHANNELS * tdcwd_pkg::MAX_HITS];
  logic [tdcwd_pkg::CNT_W-1:0]  cnt_rd_q;
  logic                         cnt_rv_q;
  logic [tdcwd_pkg::TIME_W-1:0] time_rd_q;
  logic [tdcwd_pkg::CH_IDX_W-1:0] idx_q;

  // access side
  logic [tdcwd_pkg::CHAN_W-1:0]   sel_ch;
  logic [tdcwd_pkg::CH_IDX_W-1:0] sel_idx;
  logic                           sel_ok;
  logic                           rd_in_range;
  logic [tdcwd_pkg::TADDR_W-1:0]  time_raddr;

  // exec side
  tdcwd_pkg::kind_e               kind;
  logic [tdcwd_pkg::CNT_W-1:0]    cnt;
  logic                           is_push, is_read, is_clear, live;
  logic                           store;
  logic [tdcwd_pkg::TADDR_W-1:0]  time_waddr;
  tdcwd_pkg::res_t                res_d, res_q;

  // count memory is addressed by the measurement channel for a push, else by the read channel
  assign sel_ch  = (tdcwd_pkg::op_e'(opcode_i) == tdcwd_pkg::OP_PUSH) ?
                   data_word_i[25:19] : read_channel_i;
  assign sel_idx = sel_ch[tdcwd_pkg::CH_IDX_W-1:0];
  assign sel_ok  = 32'(sel_ch) < tdcwd_pkg::CHANNELS;
  assign rd_in_range = sel_ok && (32'(read_hit_i) < tdcwd_pkg::MAX_HITS);
  assign time_raddr  = tdcwd_pkg::TADDR_W'(32'(read_channel_i) * tdcwd_pkg::MAX_HITS
                                           + 32'(read_hit_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= opcode_i;
      word_q   <= data_word_i;
      rhit_q   <= read_hit_i;
      ch_ok_q  <= sel_ok;
      hit_ok_q <= rd_in_range;
      idx_q    <= sel_idx;
      if (sel_ok) begin
        cnt_rd_q <= cnt_mem[sel_idx];
        cnt_rv_q <= cnt_vld_q[sel_idx];
      end else begin
        cnt_rd_q <= '0;
        cnt_rv_q <= 1'b0;
      end
      if (rd_in_range && tdcwd_pkg::op_e'(opcode_i) == tdcwd_pkg::OP_READ) begin
        time_rd_q <= time_mem[time_raddr];
      end
    end
  end

  // exec step
  assign kind     = tdcwd_pkg::classify(word_q);
  assign is_push  = (tdcwd_pkg::op_e'(op_q) == tdcwd_pkg::OP_PUSH);
  assign is_read  = (tdcwd_pkg::op_e'(op_q) == tdcwd_pkg::OP_READ);
  assign is_clear = (tdcwd_pkg::op_e'(op_q) == tdcwd_pkg::OP_CLEAR);
  assign live     = !trailer_q;
  assign cnt      = cnt_rv_q ? cnt_rd_q : '0;
  assign store    = cmd_i.exec && is_push && live && (kind == tdcwd_pkg::KIND_MEAS) &&
                    ch_ok_q && (32'(cnt) < tdcwd_pkg::MAX_HITS);
  assign time_waddr = tdcwd_pkg::TADDR_W'(32'(word_q[25:19]) * tdcwd_pkg::MAX_HITS
                                          + 32'(cnt));

  always_comb begin
    event_d   = event_q;
    slot_d    = slot_q;
    trailer_d = trailer_q;
    wcnt_d    = wcnt_q;
    cnt_vld_d = cnt_vld_q;
    if (cmd_i.exec) begin
      if (is_push && live) begin
        if (wcnt_q != '1) wcnt_d = wcnt_q + 1'b1;
        if (kind == tdcwd_pkg::KIND_GHDR) begin
          event_d = word_q[26:5];
          slot_d  = word_q[4:0];
        end
        if (kind == tdcwd_pkg::KIND_GTRL) trailer_d = 1'b1;
      end
      if (store) cnt_vld_d[idx_q] = 1'b1;
      if (is_clear) begin
        cnt_vld_d = '0;
        trailer_d = 1'b0;
        wcnt_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_q   <= '0;
      slot_q    <= '0;
      trailer_q <= 1'b0;
      wcnt_q    <= '0;
      cnt_vld_q <= '0;
    end else begin
      event_q   <= event_d;
      slot_q    <= slot_d;
      trailer_q <= trailer_d;
      wcnt_q    <= wcnt_d;
      cnt_vld_q <= cnt_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      cnt_mem[idx_q]        <= cnt + 1'b1;
      time_mem[time_waddr]  <= word_q[18:0];
    end
  end

  // result
  always_comb begin
    res_d = '0;
    res_d.event_number = event_d;
    res_d.slot_number  = slot_d;
    res_d.event_done   = trailer_d;
    res_d.words_seen   = wcnt_d;
    if (is_push) begin
      res_d.word_kind = kind;
      if (kind == tdcwd_pkg::KIND_MEAS) begin
        res_d.hit_channel = word_q[25:19];
        res_d.hit_time    = word_q[18:0];
      end else if (kind == tdcwd_pkg::KIND_ERROR) begin
        res_d.error_chip  = word_q[25:24];
        res_d.error_flags = word_q[14:0];
      end
      res_d.hit_stored = store;
    end
    if (is_read && ch_ok_q) begin
      res_d.read_count = tdcwd_pkg::RCNT_W'(cnt);
      if (hit_ok_q && (32'(rhit_q) < 32'(cnt))) res_d.read_value = time_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== src/tdc_word_decoder_hit_store_core.sv =====
// Usage
//   Slave stream s_axis carries one request: tuser is the opcode (push word,
//   read stored hit, clear event), tdata the word and read coordinates.
//   Master stream m_axis returns exactly one result per request: tuser is the
//   word kind, tdata the decoded fields and event status.
// Capture takes the request and memory reads; exec then loads the result register.
// A new request is not taken while one executes; the per-channel hit count is read
//   from its memory in the capture cycle and written back in the exec cycle.
// A finished result waits in the output register; the next request is taken
//   in the same cycle that register is emptied, so a stalled receiver stops
//   input after at most one request in flight.
// Reset: event, slot, word count and done flag clear, all hit counts read as
//   zero at once through per-channel valid bits. The hit time store is not
//   cleared; a read returns an entry only when its index is below the count.
// Depends on tdcwd_pkg, tdcwd_ctrl and tdcwd_datapath.
module tdc_word_decoder_hit_store_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] data_word, [38:32] read_channel, [45:39] read_hit, [47:46] zero
  input  logic [tdcwd_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] opcode
  input  logic [tdcwd_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [21:0] event_number, [26:22] slot_number, [33:27] hit_channel,
  // [52:34] hit_time, [53] hit_stored, [54] event_done, [70:55] words_seen,
  // [72:71] error_chip, [87:73] error_flags, [106:88] read_value,
  // [114:107] read_count, [119:115] zero
  output logic [tdcwd_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // [2:0] word_kind
  output logic [tdcwd_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

  tdcwd_pkg::cmd_t cmd;
  tdcwd_pkg::res_t res;

  tdcwd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  tdcwd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (s_axis_tuser),
    .data_word_i    (s_axis_tdata[31:0]),
    .read_channel_i (s_axis_tdata[38:32]),
    .read_hit_i     (s_axis_tdata[45:39]),
    .res_o          (res)
  );

  assign m_axis_tuser = res.word_kind;
  assign m_axis_tdata = {5'd0, res.read_count, res.read_value, res.error_flags,
                         res.error_chip, res.words_seen, res.event_done,
                         res.hit_stored, res.hit_time, res.hit_channel,
                         res.slot_number, res.event_number};

`ifndef SYNTHESIS
  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is executing");

  // every accepted request yields a result once its exec step is done
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> ##1 m_axis_tvalid)
    else $error("result missing after accepted request");

  // only a measurement can enter the hit store
  a_stored_is_meas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[53]) |-> (m_axis_tuser == tdcwd_pkg::KIND_MEAS))
    else $error("hit stored for a non-measurement word");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for tdc_word_decoder_hit_store_core: predicts each result from
// its own decoder state and compares field by field. Depends on tdcwd_pkg and the
// core RTL only.
module tb;
  import tdcwd_pkg::*;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = OP_NONE;
  logic                 m_tvalid;
  logic                 m_tready = 1'b1;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  // decoder state as predicted
  logic [EVENT_W-1:0] evt_num;
  logic [SLOT_W-1:0]  evt_slot;
  logic               evt_done;
  logic [WCNT_W-1:0]  word_cnt;
  int                 hit_cnt [CHANNELS];
  logic [TIME_W-1:0]  hit_tm [CHANNELS][MAX_HITS];

  res_t        pending_decodes [$];
  int          fail_count;
  int          live_items;
  int          result_idx;
  int unsigned hold_cnt;
  bit          gaps_on;

  tdc_word_decoder_hit_store_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic kind_e kind_of(logic [WORD_W-1:0] w);
    case (w[31:27])
      TAG_FILLER: return KIND_FILLER;
      TAG_GHDR:   return KIND_GHDR;
      TAG_CHDR:   return KIND_CHDR;
      TAG_MEAS:   return KIND_MEAS;
      TAG_CTRL:   return KIND_CTRL;
      TAG_GTRL:   return KIND_GTRL;
      TAG_ERROR:  return KIND_ERROR;
      default:    return KIND_UNKNOWN;
    endcase
  endfunction

  function automatic res_t decode_request(op_e op, logic [WORD_W-1:0] w,
                                          logic [CHAN_W-1:0] rch, logic [HIDX_W-1:0] rhit);
    res_t  r;
    kind_e k;
    int    ch;
    r = '0;
    case (op)
      OP_PUSH: begin
        k = kind_of(w);
        r.word_kind = k;
        ch = int'(w[25:19]);
        if (k == KIND_MEAS) begin
          r.hit_channel = w[25:19];
          r.hit_time    = w[18:0];
        end else if (k == KIND_ERROR) begin
          r.error_chip  = w[25:24];
          r.error_flags = w[14:0];
        end
        // once the trailer is in, pushes are decoded but leave state alone
        if (!evt_done) begin
          if (word_cnt != '1) word_cnt++;
          case (k)
            KIND_GHDR: begin
              evt_num  = w[26:5];
              evt_slot = w[4:0];
            end
            KIND_MEAS: begin
              if (ch < CHANNELS && hit_cnt[ch] < MAX_HITS) begin
                hit_tm[ch][hit_cnt[ch]] = w[18:0];
                hit_cnt[ch]++;
                r.hit_stored = 1'b1;
              end
            end
            KIND_GTRL: evt_done = 1'b1;
            default: ;
          endcase
        end
      end
      OP_READ: begin
        if (int'(rch) < CHANNELS) begin
          r.read_count = hit_cnt[rch][RCNT_W-1:0];
          if (int'(rhit) < hit_cnt[rch] && int'(rhit) < MAX_HITS)
            r.read_value = hit_tm[rch][rhit];
        end
      end
      OP_CLEAR: begin
        foreach (hit_cnt[i]) hit_cnt[i] = 0;
        evt_done = 1'b0;
        word_cnt = '0;
      end
      default: ;
    endcase
    r.event_number = evt_num;
    r.slot_number  = evt_slot;
    r.event_done   = evt_done;
    r.words_seen   = word_cnt;
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("mismatch @%0t result %0d: %s", $realtime, result_idx, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want)
      flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // one request; returns at the edge where it is accepted
  task automatic send_req(op_e op, logic [WORD_W-1:0] w = '0,
                          logic [CHAN_W-1:0] rch = '0, logic [HIDX_W-1:0] rhit = '0);
    int gap;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, rhit, rch, w};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    if (!(op == OP_NONE || (op == OP_PUSH && evt_done))) live_items++;
    pending_decodes.push_back(decode_request(op, w, rch, rhit));
  endtask

  function automatic logic [WORD_W-1:0] tagged_word(logic [4:0] tag);
    logic [WORD_W-1:0] w;
    w = $urandom();
    w[31:27] = tag;
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] meas_word(logic [CHAN_W-1:0] ch,
                                                  logic [TIME_W-1:0] tm);
    logic [WORD_W-1:0] w;
    w = tagged_word(TAG_MEAS);
    w[25:19] = ch;
    w[18:0]  = tm;
    return w;
  endfunction

  // response side: stall count drawn after every accepted result
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (m_tvalid && m_tready) begin
      got.word_kind    = m_tuser;
      got.event_number = m_tdata[21:0];
      got.slot_number  = m_tdata[26:22];
      got.hit_channel  = m_tdata[33:27];
      got.hit_time     = m_tdata[52:34];
      got.hit_stored   = m_tdata[53];
      got.event_done   = m_tdata[54];
      got.words_seen   = m_tdata[70:55];
      got.error_chip   = m_tdata[72:71];
      got.error_flags  = m_tdata[87:73];
      got.read_value   = m_tdata[106:88];
      got.read_count   = m_tdata[114:107];
      if (pending_decodes.size() == 0) begin
        flag_mismatch("result with nothing outstanding");
      end else begin
        want = pending_decodes.pop_front();
        check_field("word_kind",    got.word_kind,    want.word_kind);
        check_field("event_number", got.event_number, want.event_number);
        check_field("slot_number",  got.slot_number,  want.slot_number);
        check_field("hit_channel",  got.hit_channel,  want.hit_channel);
        check_field("hit_time",     got.hit_time,     want.hit_time);
        check_field("hit_stored",   got.hit_stored,   want.hit_stored);
        check_field("event_done",   got.event_done,   want.event_done);
        check_field("words_seen",   got.words_seen,   want.words_seen);
        check_field("error_chip",   got.error_chip,   want.error_chip);
        check_field("error_flags",  got.error_flags,  want.error_flags);
        check_field("read_value",   got.read_value,   want.read_value);
        check_field("read_count",   got.read_count,   want.read_count);
      end
      result_idx++;
      hold_cnt = gaps_on ? $urandom_range(0, 11) : 0;
      m_tready <= (hold_cnt == 0);
    end else if (hold_cnt != 0) begin
      hold_cnt--;
      m_tready <= (hold_cnt == 0);
    end
  end

  // field extremes, every word kind and opcode, reads in and out of range
  task automatic test_directed();
    gaps_on = 1'b1;
    send_req(OP_PUSH, 32'hC000_0000);
    send_req(OP_PUSH, 32'hC7FF_FFFF);
    send_req(OP_PUSH, 32'h47FF_FFFF);
    send_req(OP_PUSH, 32'h0800_0000);
    send_req(OP_PUSH, 32'h03FF_FFFF);
    send_req(OP_PUSH, 32'h0000_0000);
    send_req(OP_PUSH, 32'h1FFF_FFFF);
    send_req(OP_PUSH, 32'h23FF_FFFF);
    send_req(OP_PUSH, 32'h2000_0000);
    send_req(OP_PUSH, 32'hFFFF_FFFF);
    send_req(OP_PUSH, 32'h1000_0000);
    send_req(OP_READ, $urandom(), 7'd127, 7'd0);
    send_req(OP_READ, $urandom(), 7'd127, 7'd1);
    send_req(OP_READ, $urandom(), 7'd0, 7'd0);
    send_req(OP_READ, $urandom(), 7'd5, 7'd127);
    send_req(OP_NONE, '1, '1, '1);
    send_req(OP_PUSH, 32'h4000_0000);
    send_req(OP_PUSH, 32'h87FF_FFFF);
    // after the trailer: decoded, not counted, not stored
    send_req(OP_PUSH, 32'h0203_0405);
    send_req(OP_PUSH, 32'h4123_4567);
    send_req(OP_READ, '0, 7'd4, 7'd0);
    send_req(OP_CLEAR, '1, '1, '1);
    send_req(OP_READ, '0, 7'd127, 7'd0);
  endtask

  // one channel pushed past its hit limit, then read at the top index
  task automatic test_store_full();
    logic [CHAN_W-1:0] ch;
    ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
    gaps_on = 1'b1;
    send_req(OP_CLEAR);
    send_req(OP_PUSH, tagged_word(TAG_GHDR));
    for (int i = 0; i < MAX_HITS + 3; i++) begin
      if (i < 8 || i > MAX_HITS - 4) gaps_on = 1'b1;
      else gaps_on = 1'b0;
      send_req(OP_PUSH, meas_word(ch, TIME_W'($urandom())));
    end
    gaps_on = 1'b1;
    send_req(OP_READ, $urandom(), ch, HIDX_W'(MAX_HITS - 1));
    send_req(OP_READ, $urandom(), ch, 7'd0);
    send_req(OP_READ, $urandom(), ch, HIDX_W'($urandom_range(0, 127)));
  endtask

  // mostly well-formed events with random content, some raw noise
  task automatic test_random_events();
    int                goal;
    int                nchips;
    int                nhits;
    int                pick;
    int                hidx;
    logic [CHAN_W-1:0] pool [4];
    goal = 850;
    while (live_items < goal) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      foreach (pool[i]) pool[i] = CHAN_W'($urandom_range(0, CHANNELS - 1));
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(5, 15))
          send_req(op_e'($urandom_range(0, 3)), $urandom(), CHAN_W'($urandom()),
                   HIDX_W'($urandom()));
      end else begin
        if ($urandom_range(0, 5) != 0)
          send_req(OP_CLEAR, $urandom(), CHAN_W'($urandom()), HIDX_W'($urandom()));
        send_req(OP_PUSH, tagged_word(TAG_GHDR));
        nchips = $urandom_range(1, 4);
        for (int c = 0; c < nchips; c++) begin
          send_req(OP_PUSH, tagged_word(TAG_CHDR));
          nhits = ($urandom_range(0, 14) == 0) ? MAX_HITS + 2 : $urandom_range(0, 8);
          for (int h = 0; h < nhits; h++) begin
            pick = (nhits > MAX_HITS) ? 0 : $urandom_range(0, 3);
            send_req(OP_PUSH, meas_word(pool[pick], TIME_W'($urandom())));
            if ($urandom_range(0, 9) == 0) send_req(OP_PUSH, tagged_word(TAG_ERROR));
            if ($urandom_range(0, 4) == 0) begin
              pick = $urandom_range(0, 3);
              hidx = $urandom_range(0, hit_cnt[pool[pick]] + 1);
              if (hidx > 127) hidx = $urandom_range(0, 127);
              send_req(OP_READ, $urandom(), pool[pick], HIDX_W'(hidx));
            end
          end
          if ($urandom_range(0, 7) == 0)
            send_req(OP_PUSH, tagged_word(5'($urandom_range(0, 31))));
          send_req(OP_PUSH, tagged_word(TAG_CTRL));
        end
        send_req(OP_PUSH, tagged_word(TAG_GTRL));
        repeat ($urandom_range(0, 3)) send_req(OP_PUSH, $urandom());
        repeat ($urandom_range(1, 4))
          send_req(OP_READ, $urandom(), pool[$urandom_range(0, 3)],
                   HIDX_W'($urandom_range(0, 9)));
      end
    end
  endtask

  initial begin
    evt_num    = '0;
    evt_slot   = '0;
    evt_done   = 1'b0;
    word_cnt   = '0;
    foreach (hit_cnt[i]) hit_cnt[i] = 0;
    fail_count = 0;
    live_items = 0;
    result_idx = 0;
    hold_cnt   = 0;
    gaps_on    = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_store_full();
    test_random_events();
    s_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_decodes.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== tdc_word_decoder_hit_store_core.f =====
src/tdcwd_pkg.sv
src/tdcwd_ctrl.sv
src/tdcwd_datapath.sv
src/tdc_word_decoder_hit_store_core.sv
verif/tb.sv
